// ===== hdl/psfl_pkg.sv =====
// Shared constants, types and codes for the page slot free list allocator.
`timescale 1ns / 1ps

package psfl_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int BASE_PAGE  = 786432;

  localparam int PAGE_W  = 20;
  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  // Slot entry: {valid, last, word}
  localparam int ENTRY_W = PAGE_W + 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // input transfer: latch item, launch slot read
    logic commit;   // apply the item and load the result register
  } psfl_cmd_t;

endpackage

// ===== hdl/page_slot_free_list_allocator.sv =====
// Top level of the page slot free list allocator: controller plus datapath.
`timescale 1ns / 1ps
// A pool of SLOT_COUNT page-table slots; slot i maps virtual page BASE_PAGE + i.
// The free list is threaded through the slots' own words in a slot RAM.
//
// Input channel (in_valid / in_stall): one transfer carries an opcode.
//   Allocate pops the head slot, stores in_frame_number in it and returns its
//   page on out_given_page with status ok, or status pool-empty and page 0.
//   Free checks in_page_number; a page out of range or an unmapped slot gives
//   status bad-free and changes nothing, otherwise the slot becomes the head.
// Result channel (out_valid / out_stall): exactly one result per input item,
//   in order. The result sits in an output register until transferred.
// Timing: the accept edge launches the slot RAM read (head slot for allocate,
// addressed slot for free); the execute state then decides, writes the slot
// back and loads the result register once the output register is free.
// A new item is taken the cycle after commit, also while the previous result
// still waits, but never before the current item has committed.
// When the receiver stalls with a result held, the next item waits in its
// commit cycle, and in_stall stays high until the output register frees.
// Reset (rst_n low, synchronous) empties the pipeline and restores the list
// at once via a fill count of never-allocated slots; items are taken at once.

module page_slot_free_list_allocator import psfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [PAGE_W-1:0] in_frame_number,
  input  logic [PAGE_W-1:0] in_page_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PAGE_W-1:0] out_given_page,
  output logic [1:0]        out_status
);

  psfl_cmd_t cmd;

  // Sequence each transfer: read cycle, then commit when the output is free
  psfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // Hold list state, slot RAM and result payload
  psfl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_opcode),
    .in_frame_number(in_frame_number),
    .in_page_number (in_page_number),
    .out_given_page (out_given_page),
    .out_status     (out_status)
  );

endmodule

// ===== hdl/psfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/psfl_ctrl.sv =====
// Controller: sequences each item through read and commit, owns the result valid.
`timescale 1ns / 1ps

module psfl_ctrl import psfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output psfl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   commit;

  always_comb begin
    in_stall      = (state_r != S_IDLE);
    accept        = in_valid && !in_stall;
    commit        = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
    state_nxt     = state_r;
    out_valid_nxt = (out_valid_r && out_stall) || commit;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.capture = accept;
  assign cmd.commit  = commit;
  assign out_valid   = out_valid_r;

endmodule

// ===== hdl/psfl_dp.sv =====
// Datapath: free list head, fill count, slot RAM and result registers.
`timescale 1ns / 1ps

module psfl_dp import psfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  psfl_cmd_t         cmd,
  input  logic              in_opcode,
  input  logic [PAGE_W-1:0] in_frame_number,
  input  logic [PAGE_W-1:0] in_page_number,
  output logic [PAGE_W-1:0] out_given_page,
  output logic [1:0]        out_status
);

  // List control state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic              empty_r, empty_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  // Latched item
  opcode_t           op_r;
  logic [PAGE_W-1:0] frame_r;
  logic [IDX_W-1:0]  idx_r;
  logic              bad_range_r;

  // Result registers
  logic [PAGE_W-1:0] given_r;
  status_t           status_r;

  // Page to slot index
  logic [PAGE_W:0]   page_diff;
  logic              page_bad;
  logic [IDX_W-1:0]  rd_idx;

  // Slot RAM
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Effective slot entry
  logic              untouched;
  logic [PAGE_W-1:0] ent_word;
  logic              ent_last;
  logic              ent_valid;
  logic              link_end;

  logic [PAGE_W-1:0] given_nxt;
  status_t           status_nxt;

  assign page_diff = {1'b0, in_page_number} - (PAGE_W+1)'(BASE_PAGE);
  assign page_bad  = page_diff[PAGE_W] || (page_diff >= (PAGE_W+1)'(SLOT_COUNT));
  assign rd_idx    = (opcode_t'(in_opcode) == OP_FREE) ? page_diff[IDX_W-1:0] : head_r;

  psfl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(idx_r),
    .wr_data(ram_wdata),
    .rd_en  (cmd.capture),
    .rd_addr(rd_idx),
    .rd_data(ram_rdata)
  );

  // Slots at or above the fill count are untouched since reset: use reset contents, not RAM data.
  always_comb begin
    untouched = ({1'b0, idx_r} >= (IDX_W+1)'(fill_r));
    if (untouched) begin
      ent_word  = PAGE_W'({1'b0, idx_r} + (IDX_W+1)'(1));
      ent_last  = ({1'b0, idx_r} == (IDX_W+1)'(SLOT_COUNT - 1));
      ent_valid = 1'b0;
    end else begin
      ent_word  = ram_rdata[PAGE_W-1:0];
      ent_last  = ram_rdata[PAGE_W];
      ent_valid = ram_rdata[PAGE_W+1];
    end
    link_end = ent_last || ({1'b0, ent_word} >= (PAGE_W+1)'(SLOT_COUNT));
  end

  always_comb begin
    head_nxt   = head_r;
    empty_nxt  = empty_r;
    fill_nxt   = fill_r;
    given_nxt  = '0;
    status_nxt = ST_OK;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    if (op_r == OP_ALLOC) begin
      if (empty_r) begin
        status_nxt = ST_EMPTY;
      end else begin
        given_nxt = PAGE_W'(BASE_PAGE) + PAGE_W'(idx_r);
        if (link_end) begin
          empty_nxt = 1'b1;
        end else begin
          head_nxt = ent_word[IDX_W-1:0];
        end
        if (untouched) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        ram_we    = cmd.commit;
        ram_wdata = {1'b1, 1'b0, frame_r};
      end
    end else begin
      if (bad_range_r || !ent_valid) begin
        status_nxt = ST_BAD_FREE;
      end else begin
        // Push the slot back as the new head
        ram_we    = cmd.commit;
        ram_wdata = {1'b0, empty_r, PAGE_W'(head_r)};
        head_nxt  = idx_r;
        empty_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      empty_r <= 1'b0;
      fill_r  <= '0;
    end else if (cmd.commit) begin
      head_r  <= head_nxt;
      empty_r <= empty_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= opcode_t'(in_opcode);
      frame_r     <= in_frame_number;
      idx_r       <= rd_idx;
      bad_range_r <= page_bad;
    end
    if (cmd.commit) begin
      given_r  <= given_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_given_page = given_r;
  assign out_status     = status_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the page slot free list allocator.
`timescale 1ns / 1ps

// Each test task sends items through push_request. The task predicts the
// outcome of every accepted item and queues it. A separate checker pops one
// outcome per result transfer and compares it field by field. The pool
// predictor keeps its own copy of the slot list: head, empty flag, and each
// slot's word, last mark and mapped mark.

module testbench;
  import psfl_pkg::*;

  localparam int QUIET_LIMIT   = 5000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 10;    // latency margin after the last result
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  typedef struct {
    logic [PAGE_W-1:0] given_page;
    status_t           status;
  } outcome_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_opcode       = OP_ALLOC;
  logic [PAGE_W-1:0] in_frame_number = '0;
  logic [PAGE_W-1:0] in_page_number  = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [PAGE_W-1:0] out_given_page;
  logic [1:0]        out_status;

  // Idle and stall rates in percent of cycles.
  int send_idle_pct = 20;
  int stall_pct     = 58;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  outcome_t owed_results[$];

  // Predicted pool state.
  int unsigned       pool_head;
  bit                pool_dry;
  logic [PAGE_W-1:0] slot_word   [SLOT_COUNT];
  bit                slot_last   [SLOT_COUNT];
  bit                slot_mapped [SLOT_COUNT];

  page_slot_free_list_allocator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_frame_number(in_frame_number),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_given_page (out_given_page),
    .out_status     (out_status)
  );

  always #1 clk = ~clk;

  // Receiver: stall at random, at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Put every slot back on the list, chained in order.
  function automatic void reset_pool();
    pool_head = 0;
    pool_dry  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_word[i]   = PAGE_W'(i + 1);
      slot_last[i]   = (i == SLOT_COUNT - 1);
      slot_mapped[i] = 1'b0;
    end
  endfunction

  // Apply one item to the predicted pool and return what the block must answer.
  function automatic outcome_t apply_to_pool(opcode_t op, logic [PAGE_W-1:0] frame,
                                             logic [PAGE_W-1:0] page);
    outcome_t    res;
    int unsigned idx;
    int unsigned link;
    int          offs;
    res.given_page = '0;
    res.status     = ST_OK;
    if (op == OP_ALLOC) begin
      if (pool_dry || pool_head >= SLOT_COUNT) begin
        // Nothing left: report empty, change nothing else.
        pool_dry   = 1'b1;
        res.status = ST_EMPTY;
      end else begin
        idx  = pool_head;
        link = slot_word[idx];
        res.given_page = PAGE_W'(BASE_PAGE + idx);
        // A last mark or a link past the pool ends the list.
        if (slot_last[idx] || link >= SLOT_COUNT) begin
          pool_dry = 1'b1;
        end else begin
          pool_head = link;
        end
        slot_word[idx]   = frame;
        slot_last[idx]   = 1'b0;
        slot_mapped[idx] = 1'b1;
      end
    end else begin
      offs = int'(page) - BASE_PAGE;
      if (offs < 0 || offs >= SLOT_COUNT) begin
        res.status = ST_BAD_FREE;
      end else if (!slot_mapped[offs]) begin
        // Unmapped slot, so no double free.
        res.status = ST_BAD_FREE;
      end else begin
        slot_mapped[offs] = 1'b0;
        slot_word[offs]   = PAGE_W'(pool_head);
        slot_last[offs]   = pool_dry;
        pool_head         = offs;
        pool_dry          = 1'b0;
      end
    end
    return res;
  endfunction

  // Return a random mapped slot, or -1 when none is mapped.
  function automatic int pick_mapped_slot();
    int busy[$];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_mapped[i]) busy.push_back(i);
    end
    if (busy.size() == 0) return -1;
    return busy[$urandom_range(busy.size() - 1)];
  endfunction

  // Send one item: idle at random, present it, hold it until the transfer.
  // Valid stays high after the transfer so back-to-back items need no gap.
  task automatic push_request(input opcode_t op, input logic [PAGE_W-1:0] frame,
                              input logic [PAGE_W-1:0] page);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_frame_number <= frame;
    in_page_number  <= page;
    do @(posedge clk); while (in_stall);
    owed_results.push_back(apply_to_pool(op, frame, page));
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Field extremes and each kind of bad free.
  task automatic check_boundaries();
    push_request(OP_ALLOC, '0, '0);
    push_request(OP_ALLOC, PAGE_MAX, PAGE_MAX);
    push_request(OP_FREE, '0, PAGE_W'(BASE_PAGE));
    // Double free of the same slot.
    push_request(OP_FREE, PAGE_MAX, PAGE_W'(BASE_PAGE));
    // Just below and just past the pool.
    push_request(OP_FREE, '0, PAGE_W'(BASE_PAGE - 1));
    push_request(OP_FREE, '0, PAGE_W'(BASE_PAGE + SLOT_COUNT));
    // Final slot, never mapped yet.
    push_request(OP_FREE, '0, PAGE_W'(BASE_PAGE + SLOT_COUNT - 1));
    push_request(OP_FREE, '0, '0);
    push_request(OP_FREE, '0, PAGE_MAX);
    // Freed slot comes back first.
    push_request(OP_ALLOC, 20'hAAAAA, 20'h55555);
    push_request(OP_ALLOC, 20'h55555, 20'hAAAAA);
    push_request(OP_FREE, PAGE_MAX, PAGE_W'(BASE_PAGE + 1));
    // Pause the sender until the pipeline is empty.
    drain_results();
  endtask

  // Fill the pool until empty, allocate past the end, then free everything.
  task automatic exhaust_and_refill();
    int slot;
    while (!pool_dry) begin
      push_request(OP_ALLOC, PAGE_W'($urandom), PAGE_W'($urandom));
    end
    repeat (2) push_request(OP_ALLOC, PAGE_W'($urandom), PAGE_W'($urandom));
    // Free one slot while dry: it becomes a one-entry list with a last mark.
    slot = pick_mapped_slot();
    push_request(OP_FREE, PAGE_W'($urandom), PAGE_W'(BASE_PAGE + slot));
    push_request(OP_ALLOC, PAGE_W'($urandom), PAGE_W'($urandom));
    push_request(OP_ALLOC, PAGE_W'($urandom), PAGE_W'($urandom));
    // Release all in random order, now and then freeing a slot twice.
    slot = pick_mapped_slot();
    while (slot >= 0) begin
      push_request(OP_FREE, PAGE_W'($urandom), PAGE_W'(BASE_PAGE + slot));
      if ($urandom_range(9) == 0) begin
        push_request(OP_FREE, PAGE_W'($urandom), PAGE_W'(BASE_PAGE + slot));
      end
      slot = pick_mapped_slot();
    end
  endtask

  // Mostly well-formed traffic: allocates and frees of mapped slots, with a
  // drifting mix so occupancy sweeps up and down; the rest are bad frees.
  task automatic random_traffic(input int count);
    int                alloc_pct;
    int                slot;
    logic [PAGE_W-1:0] page;
    alloc_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(2))
          0: alloc_pct = 15;
          1: alloc_pct = 50;
          default: alloc_pct = 85;
        endcase
      end
      if ($urandom_range(99) < alloc_pct) begin
        push_request(OP_ALLOC, PAGE_W'($urandom), PAGE_W'($urandom));
      end else begin
        slot = pick_mapped_slot();
        if (slot >= 0 && $urandom_range(99) < 80) begin
          page = PAGE_W'(BASE_PAGE + slot);
        end else begin
          case ($urandom_range(3))
            0: page = PAGE_W'($urandom);
            1: page = PAGE_W'(BASE_PAGE + $urandom_range(SLOT_COUNT - 1));
            2: page = PAGE_W'(BASE_PAGE - 1 - $urandom_range(3));
            default: page = PAGE_W'(BASE_PAGE + SLOT_COUNT + $urandom_range(3));
          endcase
        end
        push_request(OP_FREE, PAGE_W'($urandom), page);
      end
    end
  endtask

  // Checker: compare every result transfer with the oldest owed outcome.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: page %h status %0d",
                 $time, out_given_page, out_status);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_given_page !== want.given_page) begin
          $display("%0t: given_page expected %h actual %h",
                   $time, want.given_page, out_given_page);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_pool();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver stalls heavily.
    check_boundaries();
    exhaust_and_refill();

    // Swap the rates.
    send_idle_pct = 58;
    stall_pct     = 20;
    random_traffic(400);

    // Full speed on both sides.
    send_idle_pct = 0;
    stall_pct     = 0;
    random_traffic(400);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/psfl_pkg.sv
hdl/psfl_ram.sv
hdl/psfl_ctrl.sv
hdl/psfl_dp.sv
hdl/page_slot_free_list_allocator.sv
verif/testbench.sv
